// ===== sv/assert_macros.svh =====
// assertion macros included by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error("assertion failed");

// antecedent implies consequent on the next clock edge
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== sv/thin_pkg.sv =====
// types and constants of the thinning sub-pass filter
`timescale 1ns / 1ps
`default_nettype none

package thin_pkg;

  localparam int unsigned CfgDataW = 11;
  localparam int unsigned SizeMin  = 4;

  typedef enum logic [1:0] {
    CFG_IMAGE_WIDTH  = 2'd0,
    CFG_IMAGE_HEIGHT = 2'd1,
    CFG_SUB_PASS     = 2'd2
  } cfg_index_e;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_e;

  typedef struct packed {
    logic px;
    logic emit;
    logic border;
    logic last;
  } stage_t;

endpackage

`default_nettype wire

// ===== sv/thin_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module thin_ram #(
  parameter int unsigned WIDTH = 2,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== sv/thinning_subpass_filter.sv =====
// top level of the zhang-suen thinning sub-pass filter
//
// s_axis carries one item per handshake: tdata[0] is the pixel, tuser is the
// command (pixel push or flush). m_axis returns the thinned pixel in tdata[0]
// with tlast on the final pixel of the frame. the cfg channel writes image
// width (index 0), image height (index 1) and sub pass (index 2); a size
// write restarts the frame. cfg_ready_o is always high.
// throughput is one item per clock unless m_axis stalls, set by the single line
// ram that is read and written back once per item. results trail the input by
// one row plus one pixel, passing the s1 register and then the output register.
// the first width+1 items of a frame give no result; flush items after the
// frame drain the remaining pixels, a flush outside a frame is dropped.
// reset returns the control registers to width 1024, height 1024, sub pass 0
// and an empty frame; the line ram and data registers are not cleared. when
// m_axis stalls, the output register holds its item and one more item can
// enter behind it before s_axis_tready falls.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module thinning_subpass_filter
  import thin_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // bit 0 pixel_in
  input  wire logic                s_axis_tuser,   // bit 0 cmd
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [7:0]               m_axis_tdata,   // bit 0 pixel_out
  output logic                     m_axis_tlast,
  input  wire logic                cfg_valid_i,
  output logic                     cfg_ready_o,
  input  wire logic [1:0]          cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);
  localparam logic [WW-1:0] WidthReset  = WW'((MAX_WIDTH < 1024) ? MAX_WIDTH : 1024);
  localparam logic [HW-1:0] HeightReset = HW'((MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024);

  logic [WW-1:0] w_q, w_d;
  logic [HW-1:0] h_q, h_d;
  logic          sub_pass_q, sub_pass_d;
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [8:0]    win_q, win_d;
  logic          s1_valid_q, s1_valid_d;
  stage_t        s1_q, s1_d;
  logic [CW-1:0] s1_col_q;
  logic          out_valid_q, out_valid_d;
  logic          out_px_q, out_last_q;

  logic          cfg_we, restart_cfg;
  logic          accept, ignored, process, s1_advance, s1_free;
  logic          px_eff, emit, border, last;
  logic [RW-1:0] orow;
  logic [CW-1:0] ocol, w_last;
  logic [RW-1:0] h_last;
  logic [WW-1:0] col_inc;
  logic [1:0]    ram_rdata;
  logic [8:0]    win_shift;
  logic          dec_val;

  logic nw, no, ne, we, me, ea, sw, so, se;
  logic [3:0] trans, ones;
  logic m1, m2;

  // configuration
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i;

  always_comb begin
    w_d         = w_q;
    h_d         = h_q;
    sub_pass_d  = sub_pass_q;
    restart_cfg = 1'b0;
    if (cfg_we) begin
      case (cfg_index_i)
        CFG_IMAGE_WIDTH: begin
          restart_cfg = 1'b1;
          if (32'(cfg_data_i) < SizeMin) begin
            w_d = WW'(SizeMin);
          end else if (32'(cfg_data_i) > MAX_WIDTH) begin
            w_d = WW'(MAX_WIDTH);
          end else begin
            w_d = WW'(cfg_data_i);
          end
        end
        CFG_IMAGE_HEIGHT: begin
          restart_cfg = 1'b1;
          if (32'(cfg_data_i) < SizeMin) begin
            h_d = HW'(SizeMin);
          end else if (32'(cfg_data_i) > MAX_HEIGHT) begin
            h_d = HW'(MAX_HEIGHT);
          end else begin
            h_d = HW'(cfg_data_i);
          end
        end
        CFG_SUB_PASS: begin
          sub_pass_d = cfg_data_i[0];
        end
        default: begin
        end
      endcase
    end
  end

  // input stage
  assign s1_advance    = s1_valid_q && !(s1_q.emit && out_valid_q && !m_axis_tready);
  assign s1_free       = !s1_valid_q || s1_advance;
  assign s_axis_tready = s1_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign ignored       = (s_axis_tuser == CMD_FLUSH) && (row_q == '0) && (col_q == '0);
  assign process       = accept && !ignored;

  assign w_last  = CW'(w_q - WW'(1));
  assign h_last  = RW'(h_q) - RW'(1);
  assign col_inc = WW'(col_q) + WW'(1);

  always_comb begin
    px_eff = s_axis_tdata[0];
    if ((s_axis_tuser == CMD_FLUSH) || (row_q >= RW'(h_q))) begin
      px_eff = 1'b0;
    end
    emit = (row_q >= RW'(2)) || ((row_q == RW'(1)) && (col_q != '0));
    if (col_q != '0) begin
      orow = row_q - RW'(1);
      ocol = col_q - CW'(1);
    end else begin
      orow = row_q - RW'(2);
      ocol = w_last;
    end
    border = (orow == '0) || (orow == h_last) || (ocol == '0) || (ocol == w_last);
    last   = (orow == h_last) && (ocol == w_last);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_cfg) begin
      col_d = '0;
      row_d = '0;
    end else if (process) begin
      if (emit && last) begin
        col_d = '0;
        row_d = '0;
      end else if (col_inc >= w_q) begin
        col_d = '0;
        row_d = row_q + RW'(1);
      end else begin
        col_d = CW'(col_inc);
      end
    end
  end

  always_comb begin
    s1_d        = s1_q;
    s1_valid_d  = s1_valid_q;
    if (process) begin
      s1_valid_d  = 1'b1;
      s1_d.px     = px_eff;
      s1_d.emit   = emit;
      s1_d.border = border;
      s1_d.last   = last;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // line buffers: bit 0 upper line, bit 1 middle line
  thin_ram #(
    .WIDTH(2),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (s1_advance),
    .waddr_i(s1_col_q),
    .wdata_i({s1_q.px, ram_rdata[1]}),
    .re_i   (process),
    .raddr_i(col_q),
    .rdata_o(ram_rdata)
  );

  // window and decision
  assign win_shift = {s1_q.px, ram_rdata[1], ram_rdata[0], win_q[8:3]};

  assign nw = win_shift[0];
  assign we = win_shift[1];
  assign sw = win_shift[2];
  assign no = win_shift[3];
  assign me = win_shift[4];
  assign so = win_shift[5];
  assign ne = win_shift[6];
  assign ea = win_shift[7];
  assign se = win_shift[8];

  always_comb begin
    trans = 4'(!no && ne) + 4'(!ne && ea) + 4'(!ea && se) + 4'(!se && so) +
            4'(!so && sw) + 4'(!sw && we) + 4'(!we && nw) + 4'(!nw && no);
    ones  = 4'(no) + 4'(ne) + 4'(ea) + 4'(se) + 4'(so) + 4'(sw) + 4'(we) + 4'(nw);
    if (!sub_pass_q) begin
      m1 = no & ea & so;
      m2 = ea & so & we;
    end else begin
      m1 = no & ea & we;
      m2 = no & so & we;
    end
    dec_val = me;
    if (!s1_q.border && (trans == 4'd1) && (ones >= 4'd2) && (ones <= 4'd6) && !m1 && !m2) begin
      dec_val = 1'b0;
    end
  end

  always_comb begin
    win_d = win_q;
    if (restart_cfg) begin
      win_d = '0;
    end else if (s1_advance) begin
      win_d = (s1_q.emit && s1_q.last) ? 9'd0 : win_shift;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_advance && s1_q.emit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_q         <= WidthReset;
      h_q         <= HeightReset;
      sub_pass_q  <= 1'b0;
      col_q       <= '0;
      row_q       <= '0;
      win_q       <= '0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      w_q         <= w_d;
      h_q         <= h_d;
      sub_pass_q  <= sub_pass_d;
      col_q       <= col_d;
      row_q       <= row_d;
      win_q       <= win_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q <= s1_d;
    if (process) begin
      s1_col_q <= col_q;
    end
    if (s1_advance && s1_q.emit) begin
      out_px_q   <= dec_val;
      out_last_q <= s1_q.last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_px_q};
  assign m_axis_tlast  = out_last_q;

  `ASSERT_ALWAYS(a_col_in_row, WW'(col_q) < w_q)
  `ASSERT_ALWAYS(a_row_bound, row_q <= RW'(h_q) + RW'(1))
  `ASSERT_NEXT(a_frame_restart, process && emit && last && !restart_cfg,
               (col_q == '0) && (row_q == '0))
  `ASSERT_NEXT(a_result_loaded, s1_advance && s1_q.emit, m_axis_tvalid)

endmodule

`default_nettype wire
